// ===== src/alignment_column_profiler_assert.svh =====
// assertion macros for the alignment column profiler
`ifndef ALIGNMENT_COLUMN_PROFILER_ASSERT_SVH
`define ALIGNMENT_COLUMN_PROFILER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define ACP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acp check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ACP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acp check failed");

`endif

// ===== src/acp_pkg.sv =====
// shared types, constants and helper function of the column profiler
package acp_pkg;

  localparam int MAX_SEQS    = 256;
  localparam int CNT_W       = 9;
  localparam int COL_W       = 16;
  localparam int LEN_W       = 17;
  localparam int THR_W       = 16;
  localparam int LOG_W       = 28;
  localparam int SUM_W       = 36;
  localparam int DIVD_W      = 41;
  localparam int DIVS_W      = 26;
  localparam int PAIR_W      = 20;
  localparam int SCL_W       = 26;

  localparam logic [15:0] CONS_MAX  = 16'd32768;
  localparam logic [2:0]  CONS_A    = 3'd0;
  localparam logic [2:0]  CONS_C    = 3'd1;
  localparam logic [2:0]  CONS_G    = 3'd2;
  localparam logic [2:0]  CONS_T    = 3'd3;
  localparam logic [2:0]  CONS_N    = 3'd4;

  localparam logic [0:0]  REG_THRESHOLD = 1'b0;
  localparam logic [0:0]  REG_MIN_LEN   = 1'b1;

  localparam logic [15:0] THRESHOLD_RST = 16'd16384;
  localparam logic [16:0] MIN_LEN_RST   = 17'd3;

  typedef enum logic [2:0] {
    CLS_A   = 3'd0,
    CLS_C   = 3'd1,
    CLS_G   = 3'd2,
    CLS_T   = 3'd3,
    CLS_GAP = 3'd4,
    CLS_BAD = 3'd5
  } char_cls_t;

  typedef struct packed {
    logic [4:0][CNT_W-1:0] base;
    logic [3:0][CNT_W-1:0] lower;
    logic                  bad;
    logic                  last_col;
  } col_rec_t;

  // elaboration-time log2 in Q.24, same truncation as the hardware unit
  function automatic logic [LOG_W-1:0] log2_q24(input logic [31:0] x);
    logic [63:0] m;
    logic [23:0] frac;
    logic [4:0]  msb;
    begin
      msb  = 5'd0;
      frac = 24'd0;
      for (int i = 0; i < 31; i++) begin
        if ((x >> (i + 1)) != 32'd0) msb = 5'(i + 1);
      end
      m = ({32'd0, x} << 30) >> msb;
      for (int i = 0; i < 24; i++) begin
        m    = (m * m) >> 30;
        frac = {frac[22:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      log2_q24 = {msb[3:0], frac};
    end
  endfunction

  localparam logic [LOG_W-1:0] LOG2_5 = log2_q24(32'd5);

  // floor(2^41 / LOG2_5), the Q.24 log2(5); scales (L - H) to Q1.15 with at most one step short
  localparam logic [15:0] CONS_RECIP = 16'((64'd1 << (SCL_W + 15)) / 64'(LOG2_5));

endpackage

// ===== src/alignment_column_profiler.sv =====
// top level of the alignment column profiler
//
//  channel | signals                              | role
//  in      | in_valid/in_ready, in_base_char ...  | one character of one sequence
//  out     | out_valid/out_ready, out_count_a ... | profile of one closed column
//  cfg     | cfg_valid/cfg_ready, cfg_index/data  | threshold and minimum run length
//
// characters are taken one per cycle while the column queue has room
// each closed column passes through the back end: one idle step, six serial log2
// runs, a division by n and a reciprocal multiply with a correction step (both
// skipped with no counted character), nine pair steps and one output step
// reset is synchronous, active low; no clearing pass is needed
// the front stalls only when the queue is full, the back only when the
// output register still holds an untaken result
module alignment_column_profiler #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_base_char,
  input  logic        in_last_in_column,
  input  logic        in_last_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_count_a,
  output logic [8:0]  out_count_c,
  output logic [8:0]  out_count_g,
  output logic [8:0]  out_count_t,
  output logic [8:0]  out_count_gap,
  output logic [15:0] out_conservation,
  output logic [2:0]  out_consensus,
  output logic [14:0] out_matching_pairs,
  output logic        out_region_valid,
  output logic [15:0] out_region_start,
  output logic [16:0] out_region_length,
  output logic        out_invalid_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [acp_pkg::THR_W-1:0] thr_r;
  logic [acp_pkg::LEN_W-1:0] min_len_r;
  logic                      q_push, q_pop, q_full, q_empty;
  acp_pkg::col_rec_t         q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= acp_pkg::THRESHOLD_RST;
      min_len_r <= acp_pkg::MIN_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acp_pkg::REG_THRESHOLD: thr_r     <= cfg_data[15:0];
        acp_pkg::REG_MIN_LEN:   min_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  acp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_char      (in_base_char),
    .in_last_in_column (in_last_in_column),
    .in_last_column    (in_last_column),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_in)
  );

  acp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  acp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .threshold          (thr_r),
    .min_len            (min_len_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_count_a        (out_count_a),
    .out_count_c        (out_count_c),
    .out_count_g        (out_count_g),
    .out_count_t        (out_count_t),
    .out_count_gap      (out_count_gap),
    .out_conservation   (out_conservation),
    .out_consensus      (out_consensus),
    .out_matching_pairs (out_matching_pairs),
    .out_region_valid   (out_region_valid),
    .out_region_start   (out_region_start),
    .out_region_length  (out_region_length),
    .out_invalid_char   (out_invalid_char)
  );

`include "alignment_column_profiler_assert.svh"

  `ACP_ASSERT_IMPL(a_no_overflow, q_push, !q_full)
  `ACP_ASSERT_IMPL(a_cons_range, out_valid, out_conservation <= acp_pkg::CONS_MAX && out_consensus <= acp_pkg::CONS_N)
  `ACP_ASSERT_IMPL(a_region_idle, out_valid && !out_region_valid, out_region_start == '0 && out_region_length == '0)
  `ACP_ASSERT_NEXT(a_pop_nonempty, q_pop, !q_empty || q_push || !q_full)

endmodule

// ===== src/acp_fifo.sv =====
// small register queue carrying finished column records
module acp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  acp_pkg::col_rec_t push_data,
  input  logic              pop,
  output acp_pkg::col_rec_t pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  acp_pkg::col_rec_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== src/acp_front.sv =====
// front end: classifies characters and counts them per column
module acp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_base_char,
  input  logic              in_last_in_column,
  input  logic              in_last_column,
  input  logic              q_full,
  output logic              q_push,
  output acp_pkg::col_rec_t q_data
);

  logic [4:0][acp_pkg::CNT_W-1:0] base_r, base_nxt;
  logic [3:0][acp_pkg::CNT_W-1:0] lower_r, lower_nxt;
  logic                           bad_r, bad_nxt;
  acp_pkg::char_cls_t             cls;
  logic                           is_lower;
  logic                           acc;
  logic [acp_pkg::CNT_W+1:0]      total;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && in_last_in_column;

  always_comb begin
    is_lower = 1'b0;
    case (in_base_char)
      8'h41: cls = acp_pkg::CLS_A;
      8'h43: cls = acp_pkg::CLS_C;
      8'h47: cls = acp_pkg::CLS_G;
      8'h54: cls = acp_pkg::CLS_T;
      8'h61: begin cls = acp_pkg::CLS_A; is_lower = 1'b1; end
      8'h63: begin cls = acp_pkg::CLS_C; is_lower = 1'b1; end
      8'h67: begin cls = acp_pkg::CLS_G; is_lower = 1'b1; end
      8'h74: begin cls = acp_pkg::CLS_T; is_lower = 1'b1; end
      8'h2d: cls = acp_pkg::CLS_GAP;
      default: cls = acp_pkg::CLS_BAD;
    endcase
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < 5; i++) total = total + (acp_pkg::CNT_W+2)'(base_r[i]);
  end

  always_comb begin
    base_nxt  = base_r;
    lower_nxt = lower_r;
    bad_nxt   = bad_r;
    if (cls == acp_pkg::CLS_BAD) begin
      bad_nxt = 1'b1;
    end else if (total < (acp_pkg::CNT_W+2)'(acp_pkg::MAX_SEQS)) begin
      base_nxt[cls] = base_r[cls] + 1'b1;
      if (is_lower) lower_nxt[cls[1:0]] = lower_r[cls[1:0]] + 1'b1;
    end
  end

  always_comb begin
    q_data.base     = base_nxt;
    q_data.lower    = lower_nxt;
    q_data.bad      = bad_nxt;
    q_data.last_col = in_last_column;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      lower_r <= '0;
      bad_r   <= 1'b0;
    end else if (acc) begin
      if (in_last_in_column) begin
        base_r  <= '0;
        lower_r <= '0;
        bad_r   <= 1'b0;
      end else begin
        base_r  <= base_nxt;
        lower_r <= lower_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

// ===== src/acp_log2.sv =====
// iterative log2 in Q.24, one squaring per cycle
module acp_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [acp_pkg::CNT_W-1:0] x,
  output logic                      done,
  output logic [acp_pkg::LOG_W-1:0] result
);

  logic [30:0] m_r, m_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [3:0]  msb_r, msb_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [61:0] sq;
  logic [31:0] m2;
  logic [38:0] xs;

  assign sq     = 62'(m_r) * 62'(m_r);
  assign m2     = sq[61:30];
  assign xs     = {x, 30'd0};
  assign done   = done_r;
  assign result = {msb_r, frac_r};

  always_comb begin
    m_nxt    = m_r;
    frac_nxt = frac_r;
    msb_nxt  = msb_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      msb_nxt = '0;
      for (int i = 1; i < acp_pkg::CNT_W; i++) begin
        if (x[i]) msb_nxt = 4'(i);
      end
      m_nxt    = 31'(xs >> msb_nxt);
      frac_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (m2[31]) begin
        frac_nxt = {frac_r[22:0], 1'b1};
        m_nxt    = m2[31:1];
      end else begin
        frac_nxt = {frac_r[22:0], 1'b0};
        m_nxt    = m2[30:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    msb_r  <= msb_nxt;
    step_r <= step_nxt;
  end

endmodule

// ===== src/acp_div.sv =====
// restoring divider, one quotient bit per cycle
module acp_div #(
  parameter int DW = 41,
  parameter int VW = 26
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial    = {rem_r, quo_r[DW-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== src/acp_back.sv =====
// back end: entropy, consensus, pairs and region tracking per column
module acp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  acp_pkg::col_rec_t         q_data,
  output logic                      q_pop,
  input  logic [acp_pkg::THR_W-1:0] threshold,
  input  logic [acp_pkg::LEN_W-1:0] min_len,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [8:0]                out_count_a,
  output logic [8:0]                out_count_c,
  output logic [8:0]                out_count_g,
  output logic [8:0]                out_count_t,
  output logic [8:0]                out_count_gap,
  output logic [15:0]               out_conservation,
  output logic [2:0]                out_consensus,
  output logic [14:0]               out_matching_pairs,
  output logic                      out_region_valid,
  output logic [15:0]               out_region_start,
  output logic [16:0]               out_region_length,
  output logic                      out_invalid_char
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b0_0000_0001,
    ST_LSTART = 9'b0_0000_0010,
    ST_LWAIT  = 9'b0_0000_0100,
    ST_ACC    = 9'b0_0000_1000,
    ST_DIV1   = 9'b0_0001_0000,
    ST_RMUL   = 9'b0_0010_0000,
    ST_RFIX   = 9'b0_0100_0000,
    ST_PAIRS  = 9'b0_1000_0000,
    ST_FIN    = 9'b1_0000_0000
  } back_st_t;

  back_st_t                     st_r, st_nxt;
  acp_pkg::col_rec_t            rec_r;
  logic [2:0]                   idx_r, idx_nxt;
  logic [3:0]                   pidx_r, pidx_nxt;
  logic [acp_pkg::SUM_W-1:0]    s_r, s_nxt;
  logic [acp_pkg::LOG_W-1:0]    ln_r, ln_nxt;
  logic [acp_pkg::CNT_W-1:0]    n_r;
  logic [15:0]                  cons_r, cons_nxt;
  logic [acp_pkg::PAIR_W-1:0]   pairs_r, pairs_nxt;
  logic [acp_pkg::SCL_W-1:0]    scl_x_r, scl_x_nxt;
  logic [15:0]                  scl_q_r, scl_q_nxt;
  logic [acp_pkg::SCL_W+15:0]   scl_prod;
  logic [acp_pkg::SCL_W+14:0]   scl_back;
  logic [acp_pkg::SCL_W+14:0]   scl_rem;
  logic [acp_pkg::COL_W-1:0]    col_r;
  logic                         in_reg_r;
  logic [acp_pkg::COL_W-1:0]    begin_r;
  logic                         out_valid_r;
  logic [acp_pkg::CNT_W+1:0]    n_sum;

  logic                         log_start, log_done;
  logic [acp_pkg::CNT_W-1:0]    log_x;
  logic [acp_pkg::LOG_W-1:0]    log_res;
  logic                         div_start, div_done;
  logic [acp_pkg::DIVD_W-1:0]   div_dvd;
  logic [acp_pkg::DIVS_W-1:0]   div_dvs;
  logic [acp_pkg::DIVD_W-1:0]   div_q;
  logic [acp_pkg::LOG_W-1:0]    q1, h;
  logic [acp_pkg::CNT_W+acp_pkg::LOG_W-1:0] klog;
  logic [acp_pkg::CNT_W-1:0]    pk;
  logic [17:0]                  pprod;
  logic                         slot_free;

  logic [2:0]                   cons_sel;
  logic [acp_pkg::CNT_W-1:0]    best_v;
  logic                         rv;
  logic [15:0]                  rs;
  logic [16:0]                  rl;
  logic [15:0]                  span;
  logic                         var_col;

  acp_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  acp_div #(
    .DW (acp_pkg::DIVD_W),
    .VW (acp_pkg::DIVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign q_pop     = (st_r == ST_IDLE) && !q_empty;

  always_comb begin
    n_sum = '0;
    for (int i = 0; i < 5; i++) n_sum = n_sum + (acp_pkg::CNT_W+2)'(q_data.base[i]);
  end

  always_comb begin
    case (idx_r)
      3'd0: log_x = rec_r.base[0];
      3'd1: log_x = rec_r.base[1];
      3'd2: log_x = rec_r.base[2];
      3'd3: log_x = rec_r.base[3];
      3'd4: log_x = rec_r.base[4];
      default: log_x = n_r;
    endcase
  end
  assign log_start = (st_r == ST_LSTART);
  assign klog      = (acp_pkg::CNT_W+acp_pkg::LOG_W)'(log_x) *
                     (acp_pkg::CNT_W+acp_pkg::LOG_W)'(log_res);

  // quotient of the division is log2 of n at most, fits in Q.24 width
  assign q1 = div_q[acp_pkg::LOG_W-1:0];
  assign h  = (ln_r > q1) ? ln_r - q1 : '0;

  // (L - H) * 32768 / L by reciprocal, then one compare to fix the last step
  assign scl_prod = (acp_pkg::SCL_W+16)'(scl_x_r) * (acp_pkg::SCL_W+16)'(acp_pkg::CONS_RECIP);
  assign scl_back = (acp_pkg::SCL_W+15)'(scl_q_r) * (acp_pkg::SCL_W+15)'(acp_pkg::LOG2_5);
  assign scl_rem  = {scl_x_r, 15'd0} - scl_back;

  always_comb begin
    div_start = (st_r == ST_ACC) && (idx_r == 3'd5) && (n_r != '0);
    div_dvd   = acp_pkg::DIVD_W'(s_r);
    div_dvs   = acp_pkg::DIVS_W'(n_r);
  end

  always_comb begin
    case (pidx_r)
      4'd0: pk = rec_r.base[4];
      4'd1: pk = rec_r.lower[0];
      4'd2: pk = rec_r.lower[1];
      4'd3: pk = rec_r.lower[2];
      4'd4: pk = rec_r.lower[3];
      4'd5: pk = rec_r.base[0] - rec_r.lower[0];
      4'd6: pk = rec_r.base[1] - rec_r.lower[1];
      4'd7: pk = rec_r.base[2] - rec_r.lower[2];
      default: pk = rec_r.base[3] - rec_r.lower[3];
    endcase
  end
  assign pprod = (pk == '0) ? '0 : 18'(pk) * 18'(pk - 1'b1);

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    s_nxt     = s_r;
    ln_nxt    = ln_r;
    cons_nxt  = cons_r;
    pairs_nxt = pairs_r;
    scl_x_nxt = scl_x_r;
    scl_q_nxt = scl_q_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          idx_nxt = '0;
          s_nxt   = '0;
          st_nxt  = ST_LSTART;
        end
      end
      ST_LSTART: st_nxt = ST_LWAIT;
      ST_LWAIT: begin
        if (log_done) st_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (idx_r == 3'd5) begin
          ln_nxt = log_res;
          if (n_r == '0) begin
            cons_nxt  = acp_pkg::CONS_MAX;
            pidx_nxt  = '0;
            pairs_nxt = '0;
            st_nxt    = ST_PAIRS;
          end else begin
            st_nxt = ST_DIV1;
          end
        end else begin
          s_nxt   = s_r + acp_pkg::SUM_W'(klog);
          idx_nxt = idx_r + 1'b1;
          st_nxt  = ST_LSTART;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          if (h >= acp_pkg::LOG2_5) begin
            cons_nxt  = '0;
            pidx_nxt  = '0;
            pairs_nxt = '0;
            st_nxt    = ST_PAIRS;
          end else begin
            scl_x_nxt = acp_pkg::SCL_W'(acp_pkg::LOG2_5 - h);
            st_nxt    = ST_RMUL;
          end
        end
      end
      ST_RMUL: begin
        scl_q_nxt = scl_prod[acp_pkg::SCL_W+15:acp_pkg::SCL_W];
        st_nxt    = ST_RFIX;
      end
      ST_RFIX: begin
        cons_nxt  = (scl_rem >= (acp_pkg::SCL_W+15)'(acp_pkg::LOG2_5)) ?
                    scl_q_r + 16'd1 : scl_q_r;
        pidx_nxt  = '0;
        pairs_nxt = '0;
        st_nxt    = ST_PAIRS;
      end
      ST_PAIRS: begin
        pairs_nxt = pairs_r + acp_pkg::PAIR_W'(pprod[17:1]);
        pidx_nxt  = pidx_r + 1'b1;
        if (pidx_r == 4'd8) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // consensus: earliest of A, C, G, T among equal maxima
  always_comb begin
    cons_sel = acp_pkg::CONS_N;
    best_v   = '0;
    for (int i = 0; i < 4; i++) begin
      if (rec_r.base[i] > best_v) begin
        best_v   = rec_r.base[i];
        cons_sel = 3'(i);
      end
    end
  end

  assign var_col = ({1'b0, cons_r} < {1'b0, threshold});
  assign span    = col_r - begin_r;

  always_comb begin
    rv = 1'b0;
    rs = '0;
    rl = '0;
    if (var_col) begin
      if (rec_r.last_col) begin
        // run closed by the last column counts that column
        if ((in_reg_r ? 17'(span) + 17'd1 : 17'd1) >= min_len) begin
          rv = 1'b1;
          rs = in_reg_r ? begin_r : col_r;
          rl = in_reg_r ? 17'(span) + 17'd1 : 17'd1;
        end
      end
    end else if (in_reg_r) begin
      if (17'(span) >= min_len) begin
        rv = 1'b1;
        rs = begin_r;
        rl = 17'(span);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      in_reg_r    <= 1'b0;
      begin_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if ((st_r == ST_FIN) && slot_free) begin
        out_valid_r <= 1'b1;
        if (rec_r.last_col) begin
          col_r    <= '0;
          in_reg_r <= 1'b0;
          begin_r  <= '0;
        end else begin
          col_r <= col_r + 1'b1;
          if (var_col) begin
            if (!in_reg_r) begin
              in_reg_r <= 1'b1;
              begin_r  <= col_r;
            end
          end else begin
            in_reg_r <= 1'b0;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    s_r     <= s_nxt;
    ln_r    <= ln_nxt;
    cons_r  <= cons_nxt;
    pairs_r <= pairs_nxt;
    scl_x_r <= scl_x_nxt;
    scl_q_r <= scl_q_nxt;
    if (q_pop) begin
      rec_r <= q_data;
      n_r   <= acp_pkg::CNT_W'(n_sum);
    end
    if ((st_r == ST_FIN) && slot_free) begin
      out_count_a        <= rec_r.base[0];
      out_count_c        <= rec_r.base[1];
      out_count_g        <= rec_r.base[2];
      out_count_t        <= rec_r.base[3];
      out_count_gap      <= rec_r.base[4];
      out_conservation   <= cons_r;
      out_consensus      <= cons_sel;
      out_matching_pairs <= (pairs_r > acp_pkg::PAIR_W'(15'h7fff)) ? 15'h7fff : pairs_r[14:0];
      out_region_valid   <= rv;
      out_region_start   <= rs;
      out_region_length  <= rl;
      out_invalid_char   <= rec_r.bad;
    end
  end

endmodule

// ===== tb/tb_alignment_column_profiler.sv =====
// self-checking testbench of the alignment column profiler
`timescale 1ns / 1ps

module tb_alignment_column_profiler;

  typedef struct {
    logic [8:0]  count_a;
    logic [8:0]  count_c;
    logic [8:0]  count_g;
    logic [8:0]  count_t;
    logic [8:0]  count_gap;
    logic [15:0] conservation;
    logic [2:0]  consensus;
    logic [14:0] matching_pairs;
    logic        region_valid;
    logic [15:0] region_start;
    logic [16:0] region_length;
    logic        invalid_char;
  } col_profile_t;

  class column_scoreboard;
    bit [15:0]  threshold;
    bit [16:0]  min_len;
    int         cnt[5];
    int         low_cnt[4];
    bit [15:0]  col_idx;
    bit         in_run;
    bit [15:0]  run_begin;
    bit         bad;
    col_profile_t expected_q[$];
    int         errors;

    function new();
      threshold = acp_pkg::THRESHOLD_RST;
      min_len   = acp_pkg::MIN_LEN_RST;
      for (int i = 0; i < 5; i++) cnt[i] = 0;
      for (int i = 0; i < 4; i++) low_cnt[i] = 0;
      col_idx = 0; in_run = 0; run_begin = 0; bad = 0; errors = 0;
    endfunction

    // truncated log2 in Q.24 by repeated squaring
    function longint unsigned log2_fix(int unsigned x);
      int unsigned msb;
      longint unsigned m;
      longint unsigned frac;
      msb = 0;
      frac = 0;
      if (x == 0) return 0;
      while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
      m = (longint'(x) << 30) >> msb;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac |= 1;
          m = m >> 1;
        end
      end
      return (longint'(msb) << 24) | frac;
    endfunction

    function longint unsigned pairs(int k);
      return k == 0 ? 0 : (longint'(k) * (k - 1)) / 2;
    endfunction

    function void note_item(logic [7:0] ch, logic li, logic lc);
      int cls;
      bit lower;
      int n;
      longint unsigned s, ln, h, l5, pr;
      int unsigned cons;
      int best, bestv;
      int unsigned len;
      col_profile_t r;
      cls = -1; lower = 0; n = 0;
      case (ch)
        "A": cls = 0;
        "C": cls = 1;
        "G": cls = 2;
        "T": cls = 3;
        "a": begin cls = 0; lower = 1; end
        "c": begin cls = 1; lower = 1; end
        "g": begin cls = 2; lower = 1; end
        "t": begin cls = 3; lower = 1; end
        "-": cls = 4;
        default: cls = -1;
      endcase
      for (int i = 0; i < 5; i++) n += cnt[i];
      if (cls < 0) bad = 1;
      else if (n < acp_pkg::MAX_SEQS) begin
        cnt[cls]++;
        if (lower) low_cnt[cls]++;
        n++;
      end
      if (!li) return;

      if (n == 0) cons = 32768;
      else begin
        s = 0;
        for (int i = 0; i < 5; i++) s += longint'(cnt[i]) * log2_fix(cnt[i]);
        ln = log2_fix(n);
        s = s / n;
        h = ln > s ? ln - s : 0;
        l5 = log2_fix(5);
        if (h >= l5) cons = 0;
        else cons = ((l5 - h) << 15) / l5;
        if (cons > 32768) cons = 32768;
      end

      best = acp_pkg::CONS_N; bestv = 0;
      for (int i = 0; i < 4; i++)
        if (cnt[i] > bestv) begin
          bestv = cnt[i];
          best = i;
        end

      pr = pairs(cnt[4]);
      for (int i = 0; i < 4; i++) pr += pairs(low_cnt[i]) + pairs(cnt[i] - low_cnt[i]);
      if (pr > 'h7FFF) pr = 'h7FFF;

      r.region_valid = 0; r.region_start = 0; r.region_length = 0;
      if (cons < threshold) begin
        if (!in_run) begin
          in_run = 1;
          run_begin = col_idx;
        end
        if (lc) begin
          len = 32'(16'(col_idx - run_begin)) + 1;
          if (len >= min_len) begin
            r.region_valid = 1; r.region_start = run_begin; r.region_length = 17'(len);
          end
        end
      end else if (in_run) begin
        len = 32'(16'(col_idx - run_begin));
        if (len >= min_len) begin
          r.region_valid = 1; r.region_start = run_begin; r.region_length = 17'(len);
        end
        in_run = 0;
      end

      r.count_a = 9'(cnt[0]); r.count_c = 9'(cnt[1]); r.count_g = 9'(cnt[2]);
      r.count_t = 9'(cnt[3]); r.count_gap = 9'(cnt[4]);
      r.conservation = 16'(cons);
      r.consensus = 3'(best);
      r.matching_pairs = 15'(pr);
      r.invalid_char = bad;
      expected_q.insert(expected_q.size(), r);

      for (int i = 0; i < 5; i++) cnt[i] = 0;
      for (int i = 0; i < 4; i++) low_cnt[i] = 0;
      bad = 0;
      if (lc) begin
        col_idx = 0; in_run = 0; run_begin = 0;
      end else col_idx++;
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(col_profile_t a);
      col_profile_t e;
      if (expected_q.size() == 0) begin
        $error("column profile with none expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("count_a", e.count_a, a.count_a);
      cmp("count_c", e.count_c, a.count_c);
      cmp("count_g", e.count_g, a.count_g);
      cmp("count_t", e.count_t, a.count_t);
      cmp("count_gap", e.count_gap, a.count_gap);
      cmp("conservation", e.conservation, a.conservation);
      cmp("consensus", e.consensus, a.consensus);
      cmp("matching_pairs", e.matching_pairs, a.matching_pairs);
      cmp("region_valid", e.region_valid, a.region_valid);
      cmp("region_start", e.region_start, a.region_start);
      cmp("region_length", e.region_length, a.region_length);
      cmp("invalid_char", e.invalid_char, a.invalid_char);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_base_char;
  logic        in_last_in_column;
  logic        in_last_column;
  logic        out_valid;
  logic        out_ready;
  logic [8:0]  out_count_a, out_count_c, out_count_g, out_count_t, out_count_gap;
  logic [15:0] out_conservation;
  logic [2:0]  out_consensus;
  logic [14:0] out_matching_pairs;
  logic        out_region_valid;
  logic [15:0] out_region_start;
  logic [16:0] out_region_length;
  logic        out_invalid_char;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_data;

  alignment_column_profiler uut (.*);

  column_scoreboard sb = new();
  bit no_idle = 0;
  int items_sent = 0;
  byte alphabet[9] = '{"A", "C", "G", "T", "a", "c", "g", "t", "-"};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("alignment_column_profiler test failed");
    $finish;
  end

  always @(negedge clk)
    out_ready <= no_idle || ($urandom_range(99) >= 21);

  always @(posedge clk) begin
    col_profile_t a;
    if (rst_n && out_valid && out_ready) begin
      a.count_a = out_count_a; a.count_c = out_count_c; a.count_g = out_count_g;
      a.count_t = out_count_t; a.count_gap = out_count_gap;
      a.conservation = out_conservation; a.consensus = out_consensus;
      a.matching_pairs = out_matching_pairs; a.region_valid = out_region_valid;
      a.region_start = out_region_start; a.region_length = out_region_length;
      a.invalid_char = out_invalid_char;
      sb.check_result(a);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(logic [7:0] ch, logic li, logic lc);
    if (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    in_base_char <= ch;
    in_last_in_column <= li;
    in_last_column <= lc;
    do @(posedge clk); while (!in_ready);
    sb.note_item(ch, li, lc);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.threshold = (idx == acp_pkg::REG_THRESHOLD) ? val[15:0] : sb.threshold;
    sb.min_len = (idx == acp_pkg::REG_MIN_LEN) ? val : sb.min_len;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_column(int n, logic lc);
    byte dom;
    int r;
    logic [7:0] ch;
    dom = alphabet[$urandom_range(8)];
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6) ch = 8'($urandom_range(255));
      else if (r < 55) ch = dom;
      else ch = alphabet[$urandom_range(8)];
      if (i == n - 1) send_item(ch, 1, lc);
      else send_item(ch, 0, $urandom_range(9) == 0);
    end
  endtask

  task automatic random_phase(int target);
    int stop, n;
    stop = items_sent + target;
    while (items_sent < stop) begin
      if ($urandom_range(79) == 0) n = $urandom_range(257, 270);
      else if ($urandom_range(9) == 0) n = $urandom_range(9, 24);
      else n = $urandom_range(1, 8);
      send_column(n, $urandom_range(7) == 0);
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_base_char = 0; in_last_in_column = 0; in_last_column = 0;
    cfg_valid = 0; cfg_index = acp_pkg::REG_THRESHOLD; cfg_data = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed columns
    send_item("A", 1, 0);
    send_item("-", 0, 0); send_item("-", 1, 0);
    send_item("x", 1, 0);
    send_item("A", 0, 0); send_item("C", 0, 0); send_item("G", 0, 0);
    send_item("T", 0, 0); send_item("-", 1, 0);
    send_item("C", 0, 0); send_item("G", 0, 0); send_item("g", 0, 0);
    send_item("c", 1, 0);
    send_item("a", 0, 1); send_item("A", 0, 0); send_item("T", 1, 1);
    send_item(8'hFF, 0, 0); send_item(8'h00, 0, 0); send_item("t", 1, 1);
    wait_idle();

    random_phase(170);
    write_reg(acp_pkg::REG_THRESHOLD, 17'd32768);
    write_reg(acp_pkg::REG_MIN_LEN, 17'd1);
    no_idle = 1;
    random_phase(170);
    no_idle = 0;
    write_reg(acp_pkg::REG_THRESHOLD, 17'd0);
    write_reg(acp_pkg::REG_MIN_LEN, 17'd65536);
    random_phase(120);
    write_reg(acp_pkg::REG_THRESHOLD, 17'd26000);
    write_reg(acp_pkg::REG_MIN_LEN, 17'd2);
    send_column(4, 0);
    // sender holds off until every profile is back
    wait_idle();
    random_phase(190);
    write_reg(acp_pkg::REG_THRESHOLD, 17'd32767);
    write_reg(acp_pkg::REG_MIN_LEN, 17'd65536);
    random_phase(60);
    write_reg(acp_pkg::REG_MIN_LEN, 17'd3);
    random_phase(110);

    if (sb.errors == 0)
      $display("alignment_column_profiler test passed");
    else
      $display("alignment_column_profiler test failed");
    $finish;
  end

endmodule
